[hdl/csad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csad_pkg
// Shared types, key and register codes and digit helpers for the clock,
// stopwatch and alarm display.
// ----------------------------------------------------------------------------
package csad_pkg;

  typedef logic [3:0] digit_t;
  // index 0 is tens of minutes, index 3 units of seconds
  typedef digit_t [0:3] digits_t;

  typedef enum logic [1:0] {
    MODE_CLOCK = 2'd0,
    MODE_SET   = 2'd1,
    MODE_STOPW = 2'd2,
    MODE_ALARM = 2'd3
  } mode_e;

  localparam logic [7:0] KEY_CLOCK = 8'h01;
  localparam logic [7:0] KEY_SET   = 8'h02;
  localparam logic [7:0] KEY_STOPW = 8'h04;
  localparam logic [7:0] KEY_ALARM = 8'h08;
  localparam logic [7:0] KEY_NEXT  = 8'h10;
  localparam logic [7:0] KEY_INC   = 8'h20;

  localparam logic CFG_TICKS_PER_SEC = 1'b0;
  localparam logic CFG_ALARM_SECS    = 1'b1;

  localparam logic [9:0] TICKS_PER_SEC_RST = 10'd488;
  localparam logic [3:0] ALARM_SECS_RST    = 4'd5;

  localparam digits_t CLOCK_RST = {4'd1, 4'd7, 4'd5, 4'd1};
  localparam digits_t STOPW_RST = {4'd0, 4'd0, 4'd0, 4'd0};
  localparam digits_t ALARM_RST = {4'd1, 4'd8, 4'd0, 4'd0};

  // result word layout
  localparam int unsigned OUT_W = 16;

  function automatic digit_t digit_mod(input logic [1:0] pos);
    digit_mod = (pos == 2'd0 || pos == 2'd2) ? 4'd6 : 4'd10;
  endfunction

  // ripple a one-second carry from the units of seconds upwards
  function automatic digits_t advance_time(input digits_t d);
    digits_t r;
    logic    carry;
    digit_t  n;
    r     = d;
    carry = 1'b1;
    for (int i = 3; i >= 0; i--) begin
      if (carry) begin
        n = r[i] + 4'd1;
        if (n < digit_mod(2'(i))) begin
          r[i]  = n;
          carry = 1'b0;
        end else begin
          r[i] = 4'd0;
        end
      end
    end
    advance_time = r;
  endfunction

  function automatic digit_t bump_digit(input digit_t d, input logic [1:0] pos);
    logic [4:0] x;
    logic [4:0] m;
    x = {1'b0, d} + 5'd1;
    m = {1'b0, digit_mod(pos)};
    if (x >= m) x = x - m;
    if (x >= m) x = x - m;
    bump_digit = x[3:0];
  endfunction

  function automatic logic [7:0] seg_encode(input digit_t d);
    case (d)
      4'd0:    seg_encode = 8'h3f;
      4'd1:    seg_encode = 8'h06;
      4'd2:    seg_encode = 8'h5b;
      4'd3:    seg_encode = 8'h4f;
      4'd4:    seg_encode = 8'h66;
      4'd5:    seg_encode = 8'h6d;
      4'd6:    seg_encode = 8'h7d;
      4'd7:    seg_encode = 8'h27;
      4'd8:    seg_encode = 8'h7f;
      4'd9:    seg_encode = 8'h6f;
      default: seg_encode = 8'h00;
    endcase
  endfunction

  // what the state update hands to the display register
  typedef struct packed {
    digit_t     digit;
    logic [1:0] scan;
    mode_e      mode;
    logic       alarm_on;
  } disp_req_t;

endpackage
`default_nettype wire

[hdl/csad_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csad_core
// Time, stopwatch and alarm state with key decoding, prescaler and the
// configuration registers; one word is applied per step.
// ----------------------------------------------------------------------------
module csad_core
  import csad_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_addr_i,
  input  wire logic [9:0] cfg_wdata_i,
  input  wire logic       step_i,
  input  wire logic       op_i,
  input  wire logic [7:0] key_i,
  output disp_req_t       req_o
);

  logic [9:0] tps_q;
  logic [3:0] alarm_secs_q;

  logic [9:0] presc_q, presc_d;
  digits_t    clk_q, clk_d;
  digits_t    sw_q, sw_d;
  digits_t    alm_q, alm_d;
  mode_e      mode_q, mode_d;
  logic [1:0] edit_q, edit_d;
  logic [1:0] scan_q, scan_d;
  logic       sw_halt_q, sw_halt_d;
  logic       alm_act_q, alm_act_d;
  logic [3:0] alm_elap_q, alm_elap_d;
  logic [7:0] prev_key_q, prev_key_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= TICKS_PER_SEC_RST;
      alarm_secs_q <= ALARM_SECS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TICKS_PER_SEC: tps_q        <= cfg_wdata_i;
        CFG_ALARM_SECS:    alarm_secs_q <= cfg_wdata_i[3:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    logic [9:0] p;
    logic [3:0] e;
    presc_d    = presc_q;
    clk_d      = clk_q;
    sw_d       = sw_q;
    alm_d      = alm_q;
    mode_d     = mode_q;
    edit_d     = edit_q;
    scan_d     = scan_q;
    sw_halt_d  = sw_halt_q;
    alm_act_d  = alm_act_q;
    alm_elap_d = alm_elap_q;
    prev_key_d = prev_key_q;
    p          = presc_q + 10'd1;
    e          = alm_elap_q + 4'd1;
    if (step_i) begin
      if (op_i) begin
        if (key_i != prev_key_q) begin
          prev_key_d = key_i;
          case (key_i)
            KEY_CLOCK: mode_d = MODE_CLOCK;
            KEY_SET: begin
              mode_d = MODE_SET;
              edit_d = 2'd0;
            end
            KEY_STOPW: begin
              mode_d = MODE_STOPW;
              sw_d   = STOPW_RST;
            end
            KEY_ALARM: begin
              mode_d = MODE_ALARM;
              alm_d  = clk_q;
              edit_d = 2'd0;
            end
            KEY_NEXT: begin
              if (mode_q == MODE_SET || mode_q == MODE_ALARM) begin
                edit_d = edit_q + 2'd1;
              end else if (mode_q == MODE_STOPW) begin
                sw_halt_d = ~sw_halt_q;
              end
            end
            KEY_INC: begin
              if (mode_q == MODE_SET) begin
                clk_d[edit_q] = bump_digit(clk_q[edit_q], edit_q);
              end else if (mode_q == MODE_ALARM) begin
                alm_d[edit_q] = bump_digit(alm_q[edit_q], edit_q);
              end
            end
            default: ;
          endcase
        end
      end else begin
        scan_d  = scan_q + 2'd1;
        presc_d = p;
        if (p >= tps_q) begin
          presc_d = 10'd0;
          if (mode_q != MODE_SET) clk_d = advance_time(clk_q);
          if (mode_q == MODE_STOPW && !sw_halt_q) sw_d = advance_time(sw_q);
          if (mode_q == MODE_CLOCK && alm_act_q) begin
            alm_elap_d = e;
            if (e >= alarm_secs_q) begin
              alm_act_d  = 1'b0;
              alm_elap_d = 4'd0;
            end
          end
        end
      end
      if (clk_d == alm_d) alm_act_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q    <= '0;
      clk_q      <= CLOCK_RST;
      sw_q       <= STOPW_RST;
      alm_q      <= ALARM_RST;
      mode_q     <= MODE_CLOCK;
      edit_q     <= '0;
      scan_q     <= '0;
      sw_halt_q  <= 1'b0;
      alm_act_q  <= 1'b0;
      alm_elap_q <= '0;
      prev_key_q <= '0;
    end else begin
      presc_q    <= presc_d;
      clk_q      <= clk_d;
      sw_q       <= sw_d;
      alm_q      <= alm_d;
      mode_q     <= mode_d;
      edit_q     <= edit_d;
      scan_q     <= scan_d;
      sw_halt_q  <= sw_halt_d;
      alm_act_q  <= alm_act_d;
      alm_elap_q <= alm_elap_d;
      prev_key_q <= prev_key_d;
    end
  end

  // the display shows the state as it stands after this tick
  always_comb begin
    req_o.scan     = scan_d;
    req_o.mode     = mode_d;
    req_o.alarm_on = alm_act_d;
    case (mode_d)
      MODE_STOPW: req_o.digit = sw_d[scan_d];
      MODE_ALARM: req_o.digit = alm_d[scan_d];
      default:    req_o.digit = clk_d[scan_d];
    endcase
  end

endmodule
`default_nettype wire

[hdl/csad_disp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csad_disp
// Segment encoding, digit enable and blanking, held in the result register
// until the downstream side takes the word.
// ----------------------------------------------------------------------------
module csad_disp
  import csad_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire disp_req_t        req_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic             valid_q, valid_d;
  logic [OUT_W-1:0] data_q, data_d;
  logic [7:0]       seg;
  logic [3:0]       sel_n;

  always_comb begin
    seg = seg_encode(req_i.digit);
    if (req_i.mode == MODE_CLOCK && req_i.alarm_on) seg = 8'h00;
    sel_n  = ~(4'b0001 << req_i.scan);
    data_d = {1'b0, req_i.alarm_on, req_i.mode, sel_n, seg};
  end

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (m_axis_tready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule
`default_nettype wire

[hdl/clock_stopwatch_alarm_display.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_stopwatch_alarm_display
// MM:SS clock with set, stopwatch and alarm modes driving a multiplexed
// seven-segment display.
// ----------------------------------------------------------------------------
// Words enter an input register and are applied to the clock state from
// there; applying a scan tick also loads the result register with one
// display word, a key sample gives none. One word is accepted every cycle
// while no scan tick is waiting; a scan tick waits in the input register
// only while the result register holds a word that the downstream side has
// not yet taken, and key samples are applied even then. Configuration
// writes take effect at the next clock edge.
module clock_stopwatch_alarm_display
  import csad_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_addr_i,
  input  wire logic [9:0]       cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // key[7:0]
  input  wire logic             s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // segments[7:0], digit_select[11:8], mode_now[13:12], alarm_on[14], zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic       in_valid_q, in_valid_d;
  logic       in_op_q;
  logic [7:0] in_key_q;
  logic       out_free;
  logic       fire;
  logic       s_fire;
  disp_req_t  req;

  // a key sample never needs the result register
  assign fire          = in_valid_q && (in_op_q || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q  <= s_axis_tuser;
      in_key_q <= s_axis_tdata;
    end
  end

  csad_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (fire),
    .op_i        (in_op_q),
    .key_i       (in_key_q),
    .req_o       (req)
  );

  csad_disp u_disp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && !in_op_q),
    .req_i         (req),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_tick_gives_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !in_op_q |=> m_axis_tvalid)
    else $error("scan tick produced no display word");

  a_pending_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_op_q) && $stable(in_key_q))
    else $error("stalled input word lost or changed");

  a_one_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(~m_axis_tdata[11:8]))
    else $error("digit enable not one-cold");

  a_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] && m_axis_tdata[13:12] == MODE_CLOCK
      |-> m_axis_tdata[7:0] == 8'h00)
    else $error("alarm blanking not applied");

endmodule
`default_nettype wire
